// ----- hw/rtl/plc_pkg.sv -----
// ----------------------------------------------------------------------------
// Power-law quantizer package
// Shared widths, payload types and the rounding constant of the quantizer.
// ----------------------------------------------------------------------------
package plc_pkg;

	localparam int SAMPLE_W = 24;
	localparam int GAIN_W   = 32;
	localparam int QUANT_W  = 14;

	// Product of magnitude and gain, Q.24.
	localparam int PROD_W   = SAMPLE_W + GAIN_W;
	// First root, sqrt(t) in Q.16.
	localparam int ROOT_A_W = 32;
	// Second root, t^(3/4) in Q.16.
	localparam int ROOT_R_W = 40;

	// Rounding offset 0.4054 in Q.16.
	localparam logic [16:0] ROUND_Q16 = 17'd26568;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [GAIN_W-1:0]          gain_t;
	typedef logic signed [QUANT_W-1:0]  quant_t;

	// Per-item flags that ride alongside the arithmetic.
	typedef struct packed {
		logic neg;
		logic last;
	} item_tag_t;

endpackage

// ----- hw/rtl/plc_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// Square root cell
// One digit step of a restoring square root: takes the next bit pair of
// the radicand, tries the next root bit and hands the result to the next cell.
// ----------------------------------------------------------------------------
module plc_sqrt_cell #(
	parameter int ROOT_W = 32,
	parameter int SB_W   = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_in,
	input  logic [2*ROOT_W-1:0] rad_in,
	input  logic [ROOT_W+1:0]   rem_in,
	input  logic [ROOT_W-1:0]   root_in,
	input  logic [SB_W-1:0]     sb_in,
	output logic                valid_out,
	output logic [2*ROOT_W-1:0] rad_out,
	output logic [ROOT_W+1:0]   rem_out,
	output logic [ROOT_W-1:0]   root_out,
	output logic [SB_W-1:0]     sb_out
);

	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;

	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;
	logic             ge;
	logic [REM_W+1:0] rem_diff;

	logic                valid_q;
	logic [RAD_W-1:0]    rad_q;
	logic [REM_W-1:0]    rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [SB_W-1:0]     sb_q;

	always_comb begin
		rem_sh   = {rem_in, rad_in[RAD_W-1 -: 2]};
		trial    = (REM_W+2)'({root_in, 2'b01});
		ge       = (rem_sh >= trial);
		rem_diff = ge ? (rem_sh - trial) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= {rad_in[RAD_W-3:0], 2'b00};
			rem_q  <= rem_diff[REM_W-1:0];
			root_q <= {root_in[ROOT_W-2:0], ge};
			sb_q   <= sb_in;
		end
	end

	assign valid_out = valid_q;
	assign rad_out   = rad_q;
	assign rem_out   = rem_q;
	assign root_out  = root_q;
	assign sb_out    = sb_q;

endmodule

// ----- hw/rtl/plc_sqrt_chain.sv -----
// ----------------------------------------------------------------------------
// Square root chain
// A row of square root cells, one per root bit, that takes a new radicand
// in every enabled cycle.
// ----------------------------------------------------------------------------
module plc_sqrt_chain #(
	parameter int ROOT_W = 32,
	parameter int SB_W   = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_in,
	input  logic [2*ROOT_W-1:0] rad_in,
	input  logic [SB_W-1:0]     sb_in,
	output logic                valid_out,
	output logic [ROOT_W-1:0]   root_out,
	output logic [SB_W-1:0]     sb_out
);

	logic                valid_c [0:ROOT_W];
	logic [2*ROOT_W-1:0] rad_c   [0:ROOT_W];
	logic [ROOT_W+1:0]   rem_c   [0:ROOT_W];
	logic [ROOT_W-1:0]   root_c  [0:ROOT_W];
	logic [SB_W-1:0]     sb_c    [0:ROOT_W];

	assign valid_c[0] = valid_in;
	assign rad_c[0]   = rad_in;
	assign rem_c[0]   = '0;
	assign root_c[0]  = '0;
	assign sb_c[0]    = sb_in;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
		plc_sqrt_cell #(
			.ROOT_W (ROOT_W),
			.SB_W   (SB_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (valid_c[i]),
			.rad_in    (rad_c[i]),
			.rem_in    (rem_c[i]),
			.root_in   (root_c[i]),
			.sb_in     (sb_c[i]),
			.valid_out (valid_c[i+1]),
			.rad_out   (rad_c[i+1]),
			.rem_out   (rem_c[i+1]),
			.root_out  (root_c[i+1]),
			.sb_out    (sb_c[i+1])
		);
	end

	assign valid_out = valid_c[ROOT_W];
	assign root_out  = root_c[ROOT_W];
	assign sb_out    = sb_c[ROOT_W];

endmodule

// ----- hw/rtl/power_law_coefficient_quantizer.sv -----
// ----------------------------------------------------------------------------
// Power-law coefficient quantizer
// Quantizes a spectral coefficient as sign * floor((|x|*gain)^0.75 + 0.4054).
// ----------------------------------------------------------------------------
// The block takes one coefficient per cycle while its skid register is
// empty and returns one result per coefficient, in order. The pipeline holds
// two rows of square root cells, 32 cells for sqrt(t) and 40 cells for the
// second root, plus one input stage, one multiply stage, three stages for the
// wide product and the output register. A stalled output holds one result in
// a skid register; the whole pipeline then pauses until the result is taken.
// No clearing pass is needed.
module power_law_coefficient_quantizer
	import plc_pkg::*;
#(
	parameter int MAX_QUANT = 8191
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  sample_t sample,
	input  gain_t   gain,
	input  logic    last,
	output logic    out_valid,
	input  logic    out_ready,
	output quant_t  quantized,
	output logic    saturated,
	output logic    last_res
);

	localparam int MAG_W = ROOT_R_W - 15;
	localparam logic [MAG_W-1:0] MAXQ = MAG_W'(MAX_QUANT);
	localparam int PL_W  = 28;
	localparam int PH_W  = PROD_W - 1 - PL_W;
	localparam int WIDE_W = PROD_W - 1 + ROOT_A_W;

	logic en;

	// Input stage.
	logic                v_s1;
	logic [SAMPLE_W-1:0] mag_s1;
	gain_t               gain_s1;
	item_tag_t           tag_s1;

	// Product stage.
	logic              v_s2;
	logic [PROD_W-1:0] p_s2;
	item_tag_t         tag_s2;

	// First root chain.
	logic                  a_v;
	logic [ROOT_A_W-1:0]   a_root;
	logic [PROD_W-1+2-1:0] a_sb;
	logic [PROD_W-2:0]     a_p;
	item_tag_t             a_tag;

	// Wide product stages.
	logic                   v_s3;
	logic [PL_W+ROOT_A_W-1:0] pl_s3;
	logic [PH_W-1:0]        phi_s3;
	logic [ROOT_A_W-1:0]    a_s3;
	item_tag_t              tag_s3;

	logic                   v_s4;
	logic [PL_W+ROOT_A_W-1:0] pl_s4;
	logic [PH_W+ROOT_A_W-1:0] ph_s4;
	item_tag_t              tag_s4;

	logic                v_s5;
	logic [2*ROOT_R_W-1:0] w_s5;
	item_tag_t           tag_s5;
	logic [WIDE_W-1:0]   wide;

	// Second root chain.
	logic                r_v;
	logic [ROOT_R_W-1:0] r_root;
	item_tag_t           r_tag;

	// Result formatting.
	logic [ROOT_R_W:0] rsum;
	logic [MAG_W-1:0]  mag;
	logic              sat_nx;
	logic [MAG_W-1:0]  mag_clamp;
	quant_t            q_nx;

	// Output register and skid.
	logic   out_valid_q;
	quant_t quant_q;
	logic   sat_q;
	logic   last_q;
	logic   skid_valid_q;
	quant_t skid_quant_q;
	logic   skid_sat_q;
	logic   skid_last_q;
	logic   push;
	logic   pop;

	assign en       = !skid_valid_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= a_v;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// The negation of the most negative sample wraps to 2^23, its true magnitude.
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1      <= sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);
			gain_s1     <= gain;
			tag_s1.neg  <= sample[SAMPLE_W-1];
			tag_s1.last <= last;

			p_s2   <= PROD_W'(mag_s1) * PROD_W'(gain_s1);
			tag_s2 <= tag_s1;

			pl_s3  <= (PL_W+ROOT_A_W)'(a_p[PL_W-1:0]) * (PL_W+ROOT_A_W)'(a_root);
			phi_s3 <= a_p[PROD_W-2:PL_W];
			a_s3   <= a_root;
			tag_s3 <= a_tag;

			pl_s4  <= pl_s3;
			ph_s4  <= (PH_W+ROOT_A_W)'(phi_s3) * (PH_W+ROOT_A_W)'(a_s3);
			tag_s4 <= tag_s3;

			w_s5   <= (2*ROOT_R_W)'(wide[WIDE_W-1:8]);
			tag_s5 <= tag_s4;
		end
	end

	assign wide = {ph_s4, {PL_W{1'b0}}} + WIDE_W'(pl_s4);

	plc_sqrt_chain #(
		.ROOT_W (ROOT_A_W),
		.SB_W   (PROD_W + 1)
	) u_root_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (v_s2),
		.rad_in    ({p_s2, 8'h00}),
		.sb_in     ({p_s2[PROD_W-2:0], tag_s2}),
		.valid_out (a_v),
		.root_out  (a_root),
		.sb_out    (a_sb)
	);

	assign a_p   = a_sb[PROD_W:2];
	assign a_tag = a_sb[1:0];

	plc_sqrt_chain #(
		.ROOT_W (ROOT_R_W),
		.SB_W   (2)
	) u_root_r (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (v_s5),
		.rad_in    (w_s5),
		.sb_in     (tag_s5),
		.valid_out (r_v),
		.root_out  (r_root),
		.sb_out    (r_tag)
	);

	always_comb begin
		rsum      = (ROOT_R_W+1)'(r_root) + (ROOT_R_W+1)'(ROUND_Q16);
		mag       = rsum[ROOT_R_W:16];
		sat_nx    = (mag > MAXQ);
		mag_clamp = sat_nx ? MAXQ : mag;
		q_nx      = r_tag.neg ? QUANT_W'(-mag_clamp) : QUANT_W'(mag_clamp);
	end

	assign push = en && r_v;
	assign pop  = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (pop) begin
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (out_valid_q && !pop) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				quant_q <= skid_quant_q;
				sat_q   <= skid_sat_q;
				last_q  <= skid_last_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_quant_q <= q_nx;
				skid_sat_q   <= sat_nx;
				skid_last_q  <= r_tag.last;
			end else begin
				quant_q <= q_nx;
				sat_q   <= sat_nx;
				last_q  <= r_tag.last;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign quantized = quant_q;
	assign saturated = sat_q;
	assign last_res  = last_q;

`ifndef SYNTH
	localparam quant_t QMAX_Q = QUANT_W'(MAX_QUANT);

	// The skid register only fills behind a held result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while the output register is empty");

	// The skid register fills or stays full only while the output is stalled.
	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> $past(out_valid_q && !out_ready))
		else $error("skid filled without an output stall");

	// A clamped result carries the limit with the sign of the sample.
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && sat_q) |-> (quant_q == QMAX_Q || quant_q == QUANT_W'(-QMAX_Q)))
		else $error("saturated result does not hold the limit");
`endif

endmodule

// ----- test/power_law_coefficient_quantizer_checker.sv -----
// ----------------------------------------------------------------------------
// Power-law quantizer result checker
// Watches both channels, predicts each quantized result and compares it.
// ----------------------------------------------------------------------------
module power_law_coefficient_quantizer_checker
	import plc_pkg::*;
#(
	parameter int MAX_QUANT = 8191
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_ready,
	input  sample_t sample,
	input  gain_t   gain,
	input  logic    last,
	input  logic    out_valid,
	input  logic    out_ready,
	input  quant_t  quantized,
	input  logic    saturated,
	input  logic    last_res,
	output int      fail_count,
	output int      pending
);

	typedef struct packed {
		quant_t q;
		logic   sat;
		logic   lst;
	} quant_result_t;

	quant_result_t expected_q[$];
	int fail_total = 0;

	assign fail_count = fail_total;

	// Bitwise integer square root of a 128-bit value.
	function automatic logic [63:0] int_sqrt(input logic [127:0] v);
		logic [65:0] rem;
		logic [65:0] trial;
		logic [63:0] root;
		rem = '0;
		root = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = (rem << 2) | 66'(v[2*i +: 2]);
			trial = {root, 2'b01};
			root = root << 1;
			if (rem >= trial) begin
				rem = rem - trial;
				root[0] = 1'b1;
			end
		end
		return root;
	endfunction

	function automatic quant_result_t quantize(input sample_t s, input gain_t g,
		input logic l);
		logic [127:0] p;
		logic [127:0] a;
		logic [127:0] w;
		logic [63:0]  r;
		logic [63:0]  mag;
		logic [23:0]  mag_in;
		quant_result_t res;
		mag_in = s[23] ? (~s + 24'd1) : s;
		p = (s[23] && mag_in == 0) ? 128'h800000 : 128'(mag_in);
		p = p * 128'(g);
		a = 128'(int_sqrt(p << 8));
		w = (p * a) >> 8;
		r = int_sqrt(w);
		mag = (r + 64'(ROUND_Q16)) >> 16;
		res.sat = 1'b0;
		if (mag > 64'(MAX_QUANT)) begin
			mag = 64'(MAX_QUANT);
			res.sat = 1'b1;
		end
		res.q = s[23] ? quant_t'(-mag) : quant_t'(mag);
		res.lst = l;
		return res;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h, expected %0h", what, got, want);
		fail_total++;
	endtask

	always @(posedge clk) begin
		quant_result_t e;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_q.push_back(quantize(sample, gain, last));
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report("unexpected result", 32'({quantized, saturated, last_res}), 32'd0);
				end else begin
					e = expected_q.pop_front();
					if (quantized !== e.q) report("quantized", 32'(quantized), 32'(e.q));
					if (saturated !== e.sat) report("saturated", 32'(saturated), 32'(e.sat));
					if (last_res !== e.lst) report("last_res", 32'(last_res), 32'(e.lst));
				end
			end
		end
		pending = expected_q.size();
	end

endmodule

// ----- test/power_law_coefficient_quantizer_tb.sv -----
// ----------------------------------------------------------------------------
// Power-law quantizer testbench
// Drives directed and random coefficients with random idling on both sides;
// the checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module power_law_coefficient_quantizer_tb;
	import plc_pkg::*;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    in_valid = 1'b0;
	logic    in_ready;
	sample_t sample = '0;
	gain_t   gain = '0;
	logic    last = 1'b0;
	logic    out_valid;
	logic    out_ready = 1'b0;
	quant_t  quantized;
	logic    saturated;
	logic    last_res;
	int      fail_count;
	int      pending;

	int send_idle = 36;
	int recv_idle = 47;
	int hold_off = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;

	power_law_coefficient_quantizer uut (.*);
	power_law_coefficient_quantizer_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver readiness; a requested hold-off counts down in cycles.
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_off <= 300;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send_coef(input sample_t s, input gain_t g, input logic l);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		gain <= g;
		last <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Mostly gains from narrowed ranges, some full range.
	task automatic send_random();
		sample_t s;
		gain_t   g;
		s = sample_t'($urandom);
		case ($urandom_range(3))
			0: g = $urandom;
			1: g = $urandom >> $urandom_range(31);
			2: g = $urandom_range(32'h0200_0000);
			default: g = $urandom_range(32'h0010_0000);
		endcase
		if ($urandom_range(3) == 0) s = sample_t'($signed($urandom_range(4095)) - 2048);
		send_coef(s, g, 1'($urandom_range(1)));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: zero sample, zero gain, extremes, most negative sample.
		send_coef(24'sd0, 32'hFFFF_FFFF, 1'b0);
		send_coef(-24'sd5, 32'd0, 1'b1);
		send_coef(24'sd5, 32'd0, 1'b0);
		send_coef(24'sh7FFFFF, 32'hFFFF_FFFF, 1'b1);
		send_coef(24'sh800000, 32'hFFFF_FFFF, 1'b0);
		send_coef(24'sh800000, 32'h0000_0001, 1'b1);
		send_coef(24'sh7FFFFF, 32'h0000_0001, 1'b0);
		send_coef(24'sd1, 32'h0100_0000, 1'b1);
		send_coef(-24'sd1, 32'h0100_0000, 1'b0);
		send_coef(24'sd163840, 32'h0100_0000, 1'b1);
		send_coef(-24'sd163840, 32'h0100_0000, 1'b0);
		send_coef(24'sd164000, 32'h0100_0000, 1'b1);
		send_coef(24'sd1000, 32'h8000_0000, 1'b0);
		send_coef(24'sh555555, 32'hAAAA_AAAA, 1'b1);
		send_coef(24'shAAAAAA, 32'h5555_5555, 1'b0);
		for (int i = 0; i < 210; i++) send_random();
		// Long receiver hold-off while the sender keeps offering.
		hold_req <= 1'b1;
		for (int i = 0; i < 100; i++) send_random();
		drain();
		send_idle = 47;
		recv_idle = 36;
		for (int i = 0; i < 170; i++) send_random();
		drain();
		send_idle = 0;
		recv_idle = 0;
		for (int i = 0; i < 170; i++) send_random();
		drain();
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/plc_pkg.sv
hw/rtl/plc_sqrt_cell.sv
hw/rtl/plc_sqrt_chain.sv
hw/rtl/power_law_coefficient_quantizer.sv
test/power_law_coefficient_quantizer_checker.sv
test/power_law_coefficient_quantizer_tb.sv
